### hw/rtl/assert_macros.svh
// Assertion helpers for the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

### hw/rtl/fpma_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Shared state codes, command and status types for the fit-policy allocator.
// ----------------------------------------------------------------------------
package fpma_pkg;
    localparam int HEAP_WORDS = 512;
    localparam int HEADER_WORDS = 2;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BADREL = 2'd2;
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CHECK, S_AREAD, S_AEVAL, S_RREAD, S_RLOOK, S_REVAL,
        S_DREAD, S_DWRITE, S_PREAD, S_PEVAL, S_SREAD, S_SWRITE, S_PUT, S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic idx_clear;
        logic idx_inc;
        logic idx_dec;
        logic rd_idx;
        logic rd_prev;
        logic cap_hit;
        logic set_entry;
        logic new_entry;
        logic mark_alloc;
        logic mark_free;
        logic mark_pos;
        logic shift_down;
        logic shift_up;
        logic put_entry;
        logic count_dec;
        logic count_inc;
        logic set_nofit;
        logic set_bad;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic is_release;
        logic size_zero;
        logic bad_addr;
        logic idx_end;
        logic fits;
        logic left_zero;
        logic el_zero;
        logic lower_adj;
        logic upper_adj;
        logic place_here;
        logic idx_at_pos;
        logic table_full;
        logic sized_policy;
    } stat_t;
endpackage

### hw/rtl/fpma_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences table scans, removals, insertions and merges.
// ----------------------------------------------------------------------------
module fpma_ctrl
    import fpma_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t st,
    output cmd_t  cmd,
    output logic  lower_phase,
    output logic  busy,
    output logic  done
);
    state_t state_reg, state_next;
    logic lower_reg, lower_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            lower_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lower_reg <= lower_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lower_next = lower_reg;
        unique case (state_reg)
            S_INIT: if (!st.clearing) state_next = S_IDLE;
            S_IDLE: if (start) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!st.is_release)
                    state_next = st.size_zero ? S_DONE : S_AREAD;
                else if (st.bad_addr)
                    state_next = S_DONE;
                else
                begin
                    lower_next = 1'b1;
                    state_next = S_RLOOK;
                end
            end
            S_AREAD: state_next = st.idx_end ? S_DONE : S_AEVAL;
            S_AEVAL:
            begin
                if (!st.fits) state_next = S_AREAD;
                else if (st.left_zero) state_next = S_DREAD;
                else if (st.sized_policy) state_next = S_DREAD;
                else state_next = S_DONE;
            end
            S_RLOOK: state_next = S_RREAD;
            S_RREAD:
            begin
                if (st.idx_end)
                begin
                    if (lower_reg)
                    begin
                        lower_next = 1'b0;
                        state_next = S_RLOOK;
                    end
                    else
                        state_next = S_PREAD;
                end
                else
                    state_next = S_REVAL;
            end
            S_REVAL:
            begin
                if ((lower_reg && st.lower_adj) || (!lower_reg && st.upper_adj))
                    state_next = st.sized_policy ? S_DREAD : S_DONE;
                else
                    state_next = S_RREAD;
            end
            S_DREAD: state_next = st.idx_end ? (st.sized_policy && !st.el_zero ? S_PREAD
                                                                                : S_DONE)
                                             : S_DWRITE;
            S_DWRITE: state_next = S_DREAD;
            S_PREAD:
            begin
                if (st.table_full) state_next = S_DONE;
                else state_next = st.idx_end ? S_SREAD : S_PEVAL;
            end
            S_PEVAL: state_next = st.place_here ? S_SREAD : S_PREAD;
            S_SREAD: state_next = st.idx_at_pos ? S_PUT : S_SWRITE;
            S_SWRITE: state_next = S_SREAD;
            S_PUT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT: ;
            S_IDLE: cmd.load = start;
            S_CHECK:
            begin
                cmd.idx_clear = 1'b1;
                cmd.set_nofit = !st.is_release;
                cmd.set_bad = st.is_release && st.bad_addr;
                cmd.mark_free = st.is_release && !st.bad_addr;
            end
            S_AREAD: cmd.rd_idx = 1'b1;
            S_AEVAL:
            begin
                if (st.fits)
                begin
                    cmd.mark_alloc = 1'b1;
                    cmd.cap_hit = 1'b1;
                    cmd.set_entry = 1'b1;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_RLOOK: cmd.idx_clear = 1'b1;
            S_RREAD:
            begin
                cmd.rd_idx = 1'b1;
                if (st.idx_end && !lower_reg)
                begin
                    cmd.new_entry = 1'b1;
                    cmd.idx_clear = 1'b1;
                end
            end
            S_REVAL:
            begin
                if ((lower_reg && st.lower_adj) || (!lower_reg && st.upper_adj))
                begin
                    cmd.cap_hit = 1'b1;
                    cmd.set_entry = 1'b1;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_DREAD:
            begin
                cmd.rd_idx = 1'b1;
                if (st.idx_end)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.idx_clear = 1'b1;
                end
            end
            S_DWRITE:
            begin
                cmd.shift_down = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_PREAD:
            begin
                cmd.rd_idx = 1'b1;
                if (!st.table_full && st.idx_end) cmd.mark_pos = 1'b1;
            end
            S_PEVAL:
            begin
                if (st.place_here) cmd.mark_pos = 1'b1;
                else cmd.idx_inc = 1'b1;
            end
            S_SREAD: cmd.rd_prev = 1'b1;
            S_SWRITE:
            begin
                cmd.shift_up = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            S_PUT:
            begin
                cmd.put_entry = 1'b1;
                cmd.count_inc = 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign lower_phase = lower_reg;
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
endmodule

### hw/rtl/fpma_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Free table memory, block length memory, in-use memory and the scan index.
// ----------------------------------------------------------------------------
module fpma_datapath
    import fpma_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       lower_phase,
    input  logic [1:0] fit_policy,
    input  logic       kind,
    input  logic [8:0] request_size,
    input  logic [8:0] block_address,
    output stat_t      st,
    output logic [8:0] granted_address,
    output logic [1:0] status
);
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int LW = $clog2(HEAP_WORDS + 1);
    localparam int IW = $clog2(MAX_FREE_BLOCKS);
    localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int XW = (AW > 9) ? AW + 1 : 10;

    logic [AW-1:0] fs_mem [MAX_FREE_BLOCKS];
    logic [LW-1:0] fl_mem [MAX_FREE_BLOCKS];
    logic [LW-1:0] bl_mem [HEAP_WORDS];
    logic          use_mem [HEAP_WORDS];
    logic use_rd_reg;
    logic init_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] count_reg, idx_reg, pos_reg;
    logic [CW-1:0] idx_prev;
    logic [AW-1:0] rs_reg, es_reg;
    logic [LW-1:0] rl_reg, el_reg, len_reg;
    logic kind_reg;
    logic [8:0] size_reg, addr_reg, grant_reg;
    logic [1:0] status_reg;
    logic [XW-1:0] need, head, tail;
    logic [XW+1:0] end_sum, left, newlen;
    logic [XW-1:0] gsum;
    logic [AW-1:0] new_s;
    logic [LW-1:0] new_l;

    assign need = XW'(size_reg) + XW'(HEADER_WORDS);
    assign head = XW'(addr_reg) - XW'(HEADER_WORDS);
    assign tail = head + XW'(len_reg);
    assign end_sum = (XW+2)'(rs_reg) + (XW+2)'(rl_reg);
    assign left = (XW+2)'(rl_reg) - (XW+2)'(need);
    assign newlen = (XW+2)'(rl_reg) + (XW+2)'(len_reg);
    assign gsum = XW'(end_sum - (XW+2)'(need)) + XW'(HEADER_WORDS);
    assign idx_prev = idx_reg - CW'(1);
    assign new_s = kind_reg ? (lower_phase ? rs_reg : head[AW-1:0]) : rs_reg;
    assign new_l = kind_reg ? newlen[LW-1:0] : left[LW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_idx)
        begin
            rs_reg <= fs_mem[idx_reg[IW-1:0]];
            rl_reg <= fl_mem[idx_reg[IW-1:0]];
        end
        else if (cmd.rd_prev)
        begin
            rs_reg <= fs_mem[idx_prev[IW-1:0]];
            rl_reg <= fl_mem[idx_prev[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_free)
            len_reg <= bl_mem[addr_reg[AW-1:0]];
        if (cmd.mark_alloc && gsum < XW'(HEAP_WORDS))
            bl_mem[gsum[AW-1:0]] <= LW'(need);
    end

    always_ff @(posedge clk)
    begin
        if (init_reg)
            use_mem[clr_reg] <= 1'b0;
        else if (cmd.mark_alloc && gsum < XW'(HEAP_WORDS))
            use_mem[gsum[AW-1:0]] <= 1'b1;
        else if (cmd.mark_free)
            use_mem[addr_reg[AW-1:0]] <= 1'b0;
        if (cmd.load)
            use_rd_reg <= use_mem[block_address[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (init_reg)
        begin
            fs_mem[0] <= '0;
            fl_mem[0] <= LW'(HEAP_WORDS);
        end
        else if (cmd.set_entry)
        begin
            fs_mem[idx_reg[IW-1:0]] <= new_s;
            fl_mem[idx_reg[IW-1:0]] <= new_l;
        end
        else if (cmd.shift_down)
        begin
            fs_mem[idx_prev[IW-1:0]] <= rs_reg;
            fl_mem[idx_prev[IW-1:0]] <= rl_reg;
        end
        else if (cmd.shift_up)
        begin
            fs_mem[idx_reg[IW-1:0]] <= rs_reg;
            fl_mem[idx_reg[IW-1:0]] <= rl_reg;
        end
        else if (cmd.put_entry)
        begin
            fs_mem[pos_reg[IW-1:0]] <= es_reg;
            fl_mem[pos_reg[IW-1:0]] <= el_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            idx_reg <= '0;
            pos_reg <= '0;
            status_reg <= ST_DONE;
            grant_reg <= '0;
            kind_reg <= 1'b0;
            size_reg <= '0;
            addr_reg <= '0;
            es_reg <= '0;
            el_reg <= '0;
            init_reg <= 1'b1;
            clr_reg <= '0;
        end
        else
        begin
            if (init_reg)
            begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(HEAP_WORDS - 1)) init_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                kind_reg <= kind;
                size_reg <= request_size;
                addr_reg <= block_address;
            end
            if (cmd.load) grant_reg <= '0;
            else if (cmd.mark_alloc) grant_reg <= gsum[8:0];
            if (cmd.load) status_reg <= ST_DONE;
            else if (cmd.set_nofit) status_reg <= ST_NOFIT;
            else if (cmd.set_bad) status_reg <= ST_BADREL;
            else if (cmd.mark_alloc) status_reg <= ST_DONE;
            if (cmd.idx_clear) idx_reg <= '0;
            else if (cmd.cap_hit || cmd.idx_inc) idx_reg <= idx_reg + CW'(1);
            else if (cmd.idx_dec) idx_reg <= idx_prev;
            else if (cmd.mark_pos) idx_reg <= count_reg;
            if (cmd.mark_pos) pos_reg <= idx_reg;
            if (cmd.cap_hit)
            begin
                es_reg <= new_s;
                el_reg <= new_l;
            end
            else if (cmd.new_entry)
            begin
                es_reg <= head[AW-1:0];
                el_reg <= len_reg;
            end
            if (cmd.count_dec) count_reg <= count_reg - CW'(1);
            else if (cmd.count_inc) count_reg <= count_reg + CW'(1);
        end
    end

    assign st.clearing = init_reg;
    assign st.is_release = kind_reg;
    assign st.size_zero = (size_reg == 9'd0);
    assign st.bad_addr = (addr_reg < 9'(HEADER_WORDS)) || (XW'(addr_reg) >= XW'(HEAP_WORDS)) ||
                         !use_rd_reg;
    assign st.idx_end = (idx_reg >= count_reg);
    assign st.fits = (XW'(rl_reg) >= need);
    assign st.left_zero = !kind_reg && (XW'(rl_reg) == need);
    assign st.el_zero = (el_reg == '0);
    assign st.lower_adj = (end_sum == (XW+2)'(head));
    assign st.upper_adj = (XW'(rs_reg) == tail);
    assign st.sized_policy = (fit_policy == POL_BEST) || (fit_policy == POL_WORST);
    assign st.place_here = (fit_policy == POL_BEST) ? (el_reg <= rl_reg) :
                           (fit_policy == POL_WORST) ? (el_reg >= rl_reg) : (es_reg < rs_reg);
    assign st.idx_at_pos = (idx_reg == pos_reg);
    assign st.table_full = (count_reg >= CW'(MAX_FREE_BLOCKS));

    assign granted_address = grant_reg;
    assign status = status_reg;
endmodule

### hw/rtl/fit_policy_memory_allocator.sv
// A zero-size allocate or a bad release goes straight from the check to the result; the
// longest requests are those in which scan, removal, search and insertion each walk the
// whole free table.
// Throughput: one request at a time; busy falls in the cycle after the result strobe.
// Reset is asynchronous and active low; a clearing pass of the in-use memory then keeps
// busy high while the table restarts as one free block. Results cannot be stalled.
// ----------------------------------------------------------------------------
// Fit-policy memory allocator
// First, best and worst fit heap allocator with a sequential free table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fit_policy_memory_allocator
    import fpma_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       kind,
    input  logic [8:0] request_size,
    input  logic [8:0] block_address,
    output logic [8:0] granted_address,
    output logic [1:0] status
);
    cmd_t cmd;
    stat_t st;
    logic lower_phase;
    logic [1:0] policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) policy_reg <= POL_FIRST;
        else if (cfg_we) policy_reg <= cfg_wdata;
    end

    fpma_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd),
        .lower_phase(lower_phase), .busy(busy), .done(done)
    );

    fpma_datapath #(.MAX_FREE_BLOCKS(MAX_FREE_BLOCKS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .lower_phase(lower_phase),
        .fit_policy(policy_reg), .kind(kind), .request_size(request_size),
        .block_address(block_address), .st(st), .granted_address(granted_address),
        .status(status)
    );

    `ASSERT_NEXT(a_done_pulse, done, !done, "done lasted more than one cycle")
    `ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "request not taken")
    `ASSERT_CLK(a_done_busy, !done || busy, "done outside a request")
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Allocator testbench
// Drives allocate and release requests into the fit-policy allocator under all
// placement policies, predicts each result from a local model of the free
// table and compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
class heap_scoreboard;
    int unsigned fstart[$];
    int unsigned flen[$];
    int unsigned blen[512];
    bit          inuse[512];
    logic [1:0]  policy;
    logic [8:0]  exp_addr[$];
    logic [1:0]  exp_status[$];
    int          errors;
    int          checked;
    int          live[$];

    function new();
        fstart = {0};
        flen = {512};
        policy = fpma_pkg::POL_FIRST;
        errors = 0;
        checked = 0;
        foreach (inuse[i]) inuse[i] = 0;
    endfunction

    function void insert_free(int unsigned s, int unsigned l);
        int pos;
        pos = 0;
        if (fstart.size() >= 256) return;
        while (pos < fstart.size()) begin
            if (policy == fpma_pkg::POL_BEST) begin
                if (l <= flen[pos]) break;
            end else if (policy == fpma_pkg::POL_WORST) begin
                if (l >= flen[pos]) break;
            end else if (s < fstart[pos]) break;
            pos++;
        end
        fstart.insert(pos, s);
        flen.insert(pos, l);
    endfunction

    function void resort(int i);
        int unsigned s;
        int unsigned l;
        if (policy != fpma_pkg::POL_BEST && policy != fpma_pkg::POL_WORST) return;
        s = fstart[i];
        l = flen[i];
        fstart.delete(i);
        flen.delete(i);
        insert_free(s, l);
    endfunction

    function void note_request(bit k, int unsigned size, int unsigned addr);
        int unsigned need;
        int unsigned base;
        int unsigned head;
        int unsigned granted;
        logic [1:0]  st;
        bit          merged;
        granted = 0;
        st = fpma_pkg::ST_DONE;
        merged = 0;
        if (k == 0) begin
            need = size + 2;
            st = fpma_pkg::ST_NOFIT;
            if (size != 0) begin
                for (int i = 0; i < fstart.size(); i++) begin
                    if (flen[i] >= need) begin
                        base = fstart[i] + flen[i] - need;
                        granted = base + 2;
                        if (granted < 512) begin
                            blen[granted] = need;
                            inuse[granted] = 1;
                            live.push_back(granted);
                        end
                        if (flen[i] == need) begin
                            fstart.delete(i);
                            flen.delete(i);
                        end else begin
                            flen[i] = flen[i] - need;
                            resort(i);
                        end
                        st = fpma_pkg::ST_DONE;
                        break;
                    end
                end
            end
        end else if (addr < 2 || addr >= 512 || !inuse[addr]) begin
            st = fpma_pkg::ST_BADREL;
        end else begin
            head = addr - 2;
            inuse[addr] = 0;
            foreach (live[j]) if (live[j] == addr) begin live.delete(j); break; end
            for (int i = 0; i < fstart.size() && !merged; i++)
                if (fstart[i] + flen[i] == head) begin
                    flen[i] += blen[addr];
                    resort(i);
                    merged = 1;
                end
            for (int i = 0; i < fstart.size() && !merged; i++)
                if (fstart[i] == head + blen[addr]) begin
                    fstart[i] = head;
                    flen[i] += blen[addr];
                    resort(i);
                    merged = 1;
                end
            if (!merged) insert_free(head, blen[addr]);
        end
        exp_addr.push_back(granted[8:0]);
        exp_status.push_back(st);
    endfunction

    function void check_result(logic [8:0] ga, logic [1:0] st);
        logic [8:0] ea;
        logic [1:0] es;
        checked++;
        if (exp_addr.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result: address %0d status %0d", ga, st);
            return;
        end
        ea = exp_addr.pop_front();
        es = exp_status.pop_front();
        if (ga !== ea || st !== es) begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected address %0d status %0d, got address %0d status %0d",
                         ea, es, ga, st);
        end
    endfunction
endclass

module tb;
    import fpma_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       kind;
    logic [8:0] request_size;
    logic [8:0] block_address;
    logic [8:0] granted_address;
    logic [1:0] status;

    heap_scoreboard sb;
    int idle_pct;
    int watchdog;
    int requests;

    fit_policy_memory_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .kind(kind),
        .request_size(request_size), .block_address(block_address),
        .granted_address(granted_address), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(granted_address, status);
        if (!rst_n || done || (start && !busy)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog > 20000) begin
            $display("Timeout waiting for the allocator");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(bit k, logic [8:0] size, logic [8:0] addr);
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        start <= 1'b1;
        kind <= k;
        request_size <= size;
        block_address <= addr;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(k, size, addr);
        requests++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.exp_addr.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.policy = p;
        @(posedge clk);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            send_request(0, (r < 5) ? 9'($urandom) : 9'($urandom_range(40, 1)), 0);
        else if (r < 90 && sb.live.size() != 0)
            send_request(1, 9'($urandom),
                         9'(sb.live[$urandom_range(sb.live.size() - 1)]));
        else
            send_request(1, 9'($urandom), 9'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        kind = 1'b0;
        request_size = 9'd0;
        block_address = 9'd0;
        idle_pct = 0;
        watchdog = 0;
        requests = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(0, 9'd0, 9'd0);
        send_request(0, 9'd511, 9'd0);
        send_request(0, 9'd510, 9'd0);
        send_request(1, 9'd0, 9'd2);
        send_request(1, 9'd0, 9'd0);
        send_request(1, 9'd0, 9'd1);
        send_request(1, 9'd0, 9'd511);
        send_request(0, 9'd10, 9'd0);
        send_request(0, 9'd20, 9'd0);
        send_request(0, 9'd30, 9'd0);
        send_request(1, 9'd0, 9'd478);
        send_request(1, 9'd0, 9'd478);
        send_request(1, 9'd0, 9'd500);
        send_request(1, 9'd0, 9'd456);
        send_request(0, 9'd510, 9'd0);
        send_request(1, 9'd0, 9'd2);
        set_policy(2'd3);
        send_request(0, 9'd5, 9'd0);
        send_request(0, 9'd5, 9'd0);

        for (int ph = 0; ph < 12; ph++)
        begin
            set_policy(2'(ph % 3 == 0 ? POL_FIRST : ph % 3 == 1 ? POL_BEST : POL_WORST));
            idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 63 : (ph % 4 == 2) ? 0 : 14;
            for (int n = 0; n < 96; n++) random_request();
        end
        set_policy(POL_FIRST);
        idle_pct = 0;
        while (sb.live.size() != 0) send_request(1, 9'd0, 9'(sb.live[0]));
        drain();

        $display("Covered %0d requests over first, best and worst fit, with idle phases.",
                 requests);
        $display("Results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.exp_addr.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### fit_policy_memory_allocator.f
+incdir+hw/rtl
hw/rtl/fpma_pkg.sv
hw/rtl/fpma_ctrl.sv
hw/rtl/fpma_datapath.sv
hw/rtl/fit_policy_memory_allocator.sv
dv/tb.sv
